@@ src/psdb_pkg.sv @@
`default_nettype none

package psdb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ROT_ROW0     = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1     = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2     = 3'd2;
  localparam logic [2:0] REG_CAM_X        = 3'd3;
  localparam logic [2:0] REG_CAM_Y        = 3'd4;
  localparam logic [2:0] REG_CAM_Z        = 3'd5;
  localparam logic [2:0] REG_DEPTH_LIMITS = 3'd6;
  localparam logic [2:0] REG_PROJECTION   = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // datapath widths
  localparam int unsigned D_W    = 33;  // point minus camera
  localparam int unsigned ACC_W  = 51;  // camera space coordinate, 2^-14 mm
  localparam int unsigned MAG_W  = 50;  // magnitude of a lateral coordinate
  localparam int unsigned DVD_W  = 74;  // focal times magnitude
  localparam int unsigned DVS_W  = 50;  // sixteen times depth
  localparam int unsigned Q_W    = 41;  // quotient, saturating at 2^40
  localparam int unsigned C16_W  = 43;  // position in sixteenths of a pixel

  // input item
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [23:0]        sample_value;
  } point_t;

  // result item
  typedef struct packed {
    logic        visible;
    logic        nearer;
    logic [8:0]  pixel_col;
    logic [8:0]  pixel_row;
    logic [3:0]  sub_col;
    logic [3:0]  sub_row;
    logic [31:0] distance;
    logic [31:0] nearest_seen;
    logic [31:0] farthest_seen;
  } result_t;

endpackage

`default_nettype wire

@@ src/point_splat_depth_buffer_unit.sv @@
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------
// point     | in        | start, busy        | point_i (psdb_pkg::point_t)
// result    | out       | done_o strobe      | result_o (psdb_pkg::result_t)
// config    | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item at a time. A visible point passes through a single 16x33
// multiply-accumulate for the rotation, focal scaling in two partial products,
// the bit-serial divider (the square root runs alongside), then a read and a
// write of the depth buffer. A point dropped on depth ends after the depth check.
// After reset a clearing pass over IMG_W*IMG_H entries empties the buffers; busy is
// high during it. Each result is on result_o for the one cycle that done_o is high.
`default_nettype none

module point_splat_depth_buffer_unit #(
  parameter int unsigned IMG_W      = 512,
  parameter int unsigned IMG_H      = 512,
  parameter int unsigned PYR_LEVELS = 3
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire psdb_pkg::point_t                    point_i,
  output logic                                     done_o,
  output psdb_pkg::result_t                        result_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [psdb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [psdb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = IMG_W * IMG_H;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(IMG_W);
  localparam int unsigned RW    = $clog2(IMG_H);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MAC  = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_PMUL = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_FIN  = 4'd6;
  localparam logic [3:0] ST_ADR  = 4'd7;
  localparam logic [3:0] ST_RD   = 4'd8;

  // configuration registers
  logic [47:0] rot_row0_q, rot_row1_q, rot_row2_q;
  logic [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [63:0] depth_limits_q, projection_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row0_q     <= '0;
      rot_row1_q     <= '0;
      rot_row2_q     <= '0;
      cam_x_q        <= '0;
      cam_y_q        <= '0;
      cam_z_q        <= '0;
      depth_limits_q <= '0;
      projection_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psdb_pkg::REG_ROT_ROW0:     rot_row0_q     <= cfg_data_i[47:0];
        psdb_pkg::REG_ROT_ROW1:     rot_row1_q     <= cfg_data_i[47:0];
        psdb_pkg::REG_ROT_ROW2:     rot_row2_q     <= cfg_data_i[47:0];
        psdb_pkg::REG_CAM_X:        cam_x_q        <= cfg_data_i[31:0];
        psdb_pkg::REG_CAM_Y:        cam_y_q        <= cfg_data_i[31:0];
        psdb_pkg::REG_CAM_Z:        cam_z_q        <= cfg_data_i[31:0];
        psdb_pkg::REG_DEPTH_LIMITS: depth_limits_q <= cfg_data_i;
        psdb_pkg::REG_PROJECTION:   projection_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]  state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [1:0]  mrow_q, mcol_q;
  logic        pstep_q;
  logic [6:0]  div_cnt_q;
  logic        done_q;
  logic [31:0] dist_min_q, dist_max_q;

  // datapath registers
  logic signed [psdb_pkg::D_W-1:0]   dx_q, dy_q, dz_q;
  logic [23:0]                       sample_q;
  logic signed [psdb_pkg::ACC_W-1:0] x_q, y_q, z_q;
  logic [63:0]                       sq_q;
  logic                              ovf_q;
  logic [psdb_pkg::MAG_W-1:0]        mag_x_q, mag_y_q;
  logic                              neg_x_q, neg_y_q;
  logic [48:0]                       plo_x_q, plo_y_q;
  logic [psdb_pkg::DVS_W-1:0]        dvs_q;
  logic [psdb_pkg::DVD_W-1:0]        dvd_x_q, dvd_y_q;
  logic [psdb_pkg::DVS_W-1:0]        rem_x_q, rem_y_q;
  logic [psdb_pkg::Q_W-1:0]          q_x_q, q_y_q;
  logic [63:0]                       sn_q, sres_q, sbit_q;
  logic [CW-1:0]                     col_q;
  logic [RW-1:0]                     row_q;
  logic [8:0]                        pix_col_q, pix_row_q;
  logic [3:0]                        sub_col_q, sub_row_q;
  psdb_pkg::result_t                 res_q;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // point minus camera
  logic signed [psdb_pkg::D_W-1:0] dx_in, dy_in, dz_in;
  assign dx_in = {point_i.point_x[31], point_i.point_x} - {cam_x_q[31], cam_x_q};
  assign dy_in = {point_i.point_y[31], point_i.point_y} - {cam_y_q[31], cam_y_q};
  assign dz_in = {point_i.point_z[31], point_i.point_z} - {cam_z_q[31], cam_z_q};

  // rotation multiply-accumulate, one coefficient a cycle
  logic [47:0]                       row_sel;
  logic signed [15:0]                coef;
  logic signed [psdb_pkg::D_W-1:0]   d_sel;
  logic signed [48:0]                term;
  logic signed [psdb_pkg::ACC_W-1:0] term_x;
  logic [psdb_pkg::D_W-1:0]          d_abs;
  logic [65:0]                       d_sq;
  logic [64:0]                       sq_sum;

  always_comb begin
    case (mrow_q)
      2'd0:    row_sel = rot_row0_q;
      2'd1:    row_sel = rot_row1_q;
      default: row_sel = rot_row2_q;
    endcase
    case (mcol_q)
      2'd0:    begin coef = row_sel[47:32]; d_sel = dx_q; end
      2'd1:    begin coef = row_sel[31:16]; d_sel = dy_q; end
      default: begin coef = row_sel[15:0];  d_sel = dz_q; end
    endcase
  end

  assign term   = coef * d_sel;
  assign term_x = {{(psdb_pkg::ACC_W - 49){term[48]}}, term};
  assign d_abs  = d_sel[psdb_pkg::D_W-1] ? -d_sel : d_sel;
  assign d_sq   = d_abs * d_abs;
  assign sq_sum = {1'b0, sq_q} + {1'b0, d_sq[63:0]};

  // depth window
  logic signed [psdb_pkg::ACC_W-1:0] near_l, far_l;
  logic                              depth_ok;
  assign near_l   = {5'd0, depth_limits_q[63:32], 14'd0};
  assign far_l    = {5'd0, depth_limits_q[31:0], 14'd0};
  assign depth_ok = !(z_q < near_l) && !(z_q > far_l) && (z_q > 0);

  logic signed [psdb_pkg::ACC_W-1:0] abs_x, abs_y;
  assign abs_x = x_q[psdb_pkg::ACC_W-1] ? -x_q : x_q;
  assign abs_y = y_q[psdb_pkg::ACC_W-1] ? -y_q : y_q;

  // focal scaling in two partial products
  logic [23:0] focal;
  logic [48:0] pm_x, pm_y;
  assign focal = projection_q[63:40];
  assign pm_x  = focal * (pstep_q ? mag_x_q[49:25] : mag_x_q[24:0]);
  assign pm_y  = focal * (pstep_q ? mag_y_q[49:25] : mag_y_q[24:0]);

  // restoring divider step, both axes share the divisor
  logic [psdb_pkg::DVS_W:0]   sh_x, sh_y;
  logic                       qb_x, qb_y;
  logic [psdb_pkg::DVS_W-1:0] rem_x_d, rem_y_d;
  logic [psdb_pkg::Q_W-1:0]   q_x_d, q_y_d;

  assign sh_x    = {rem_x_q, dvd_x_q[psdb_pkg::DVD_W-1]};
  assign sh_y    = {rem_y_q, dvd_y_q[psdb_pkg::DVD_W-1]};
  assign qb_x    = (sh_x >= {1'b0, dvs_q});
  assign qb_y    = (sh_y >= {1'b0, dvs_q});
  assign rem_x_d = qb_x ? psdb_pkg::DVS_W'(sh_x - {1'b0, dvs_q}) : sh_x[psdb_pkg::DVS_W-1:0];
  assign rem_y_d = qb_y ? psdb_pkg::DVS_W'(sh_y - {1'b0, dvs_q}) : sh_y[psdb_pkg::DVS_W-1:0];
  assign q_x_d   = q_x_q[psdb_pkg::Q_W-1] ? q_x_q : {q_x_q[psdb_pkg::Q_W-2:0], qb_x};
  assign q_y_d   = q_y_q[psdb_pkg::Q_W-1] ? q_y_q : {q_y_q[psdb_pkg::Q_W-2:0], qb_y};

  // square root step
  logic [64:0] s_trial;
  logic        s_take;
  assign s_trial = {1'b0, sres_q} + {1'b0, sbit_q};
  assign s_take  = ({1'b0, sn_q} >= s_trial);

  // sixteenths position after the divide
  logic signed [psdb_pkg::C16_W-1:0] qs_x, qs_y, c16, r16;
  logic                              img_ok;
  assign qs_x = neg_x_q ? -$signed({2'b00, q_x_q}) - {42'd0, rem_x_q != '0}
                        : $signed({2'b00, q_x_q});
  assign qs_y = neg_y_q ? -$signed({2'b00, q_y_q}) - {42'd0, rem_y_q != '0}
                        : $signed({2'b00, q_y_q});
  assign c16  = qs_x - {{(psdb_pkg::C16_W - 20){projection_q[39]}}, projection_q[39:20]};
  assign r16  = qs_y - {{(psdb_pkg::C16_W - 20){projection_q[19]}}, projection_q[19:0]};
  assign img_ok = !c16[psdb_pkg::C16_W-1] && !r16[psdb_pkg::C16_W-1]
               && (c16[psdb_pkg::C16_W-1:4] < (psdb_pkg::C16_W - 4)'(IMG_W))
               && (r16[psdb_pkg::C16_W-1:4] < (psdb_pkg::C16_W - 4)'(IMG_H));

  // depth and value buffers
  logic [31:0] depth_mem [DEPTH];
  logic [23:0] value_mem [DEPTH];
  logic [31:0] depth_rd_q;
  logic [AW-1:0] pix_addr, mem_addr;
  logic [31:0] dist_mm;
  logic        nearer, in_rd, clearing;

  assign pix_addr = AW'(row_q) * AW'(IMG_W) + AW'(col_q);
  assign clearing = (state_q == ST_CLR);
  assign mem_addr = clearing ? clr_q : pix_addr;
  assign in_rd    = (state_q == ST_RD);
  assign dist_mm  = ovf_q ? 32'hFFFF_FFFF : sres_q[31:0];
  assign nearer   = (depth_rd_q == '0) || (dist_mm < depth_rd_q);

  always_ff @(posedge clk_i) begin
    if (clearing || (in_rd && nearer)) begin
      depth_mem[mem_addr] <= clearing ? 32'd0 : dist_mm;
      value_mem[mem_addr] <= clearing ? 24'hFF_FFFF : sample_q;
    end
    depth_rd_q <= depth_mem[mem_addr];
  end

  // pyramid levels, each halving the resolution of the one before and keeping its own minimum
  for (genvar lv = 1; lv <= 3; lv++) begin : g_pyr
    if (lv <= PYR_LEVELS) begin : g_lvl
      localparam int unsigned PW = (IMG_W + (1 << lv) - 1) >> lv;
      localparam int unsigned PH = (IMG_H + (1 << lv) - 1) >> lv;
      localparam int unsigned PD = PW * PH;
      localparam int unsigned PA = $clog2(PD);

      logic [31:0]   pyr_mem [PD];
      logic [31:0]   pyr_rd_q;
      logic [PA-1:0] pyr_idx, pyr_addr;
      logic          pyr_clr;

      assign pyr_idx  = PA'(row_q >> lv) * PA'(PW) + PA'(col_q >> lv);
      assign pyr_clr  = clearing && (clr_q < AW'(PD));
      assign pyr_addr = clearing ? clr_q[PA-1:0] : pyr_idx;

      always_ff @(posedge clk_i) begin
        if (pyr_clr) begin
          pyr_mem[pyr_addr] <= 32'd0;
        end else if (in_rd && ((pyr_rd_q == '0) || (pyr_rd_q > dist_mm))) begin
          pyr_mem[pyr_addr] <= dist_mm;
        end
        pyr_rd_q <= pyr_mem[pyr_addr];
      end
    end
  end

  // running extremes as updated by this item
  logic [31:0] min_new, max_new;
  assign min_new = (dist_mm < dist_min_q) ? dist_mm : dist_min_q;
  assign max_new = (dist_mm > dist_max_q) ? dist_mm : dist_max_q;

  // result item, zero apart from the extremes when the point is dropped
  psdb_pkg::result_t res_d;
  always_comb begin
    res_d               = '0;
    res_d.nearest_seen  = dist_min_q;
    res_d.farthest_seen = dist_max_q;
    if (in_rd) begin
      res_d.visible       = 1'b1;
      res_d.nearer        = nearer;
      res_d.pixel_col     = pix_col_q;
      res_d.pixel_row     = pix_row_q;
      res_d.sub_col       = sub_col_q;
      res_d.sub_row       = sub_row_q;
      res_d.distance      = dist_mm;
      res_d.nearest_seen  = min_new;
      res_d.farthest_seen = max_new;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: if (accept) state_d = ST_MAC;
      ST_MAC:  if (mrow_q == 2'd2 && mcol_q == 2'd2) state_d = ST_CHK;
      ST_CHK:  state_d = depth_ok ? ST_PMUL : ST_IDLE;
      ST_PMUL: if (pstep_q) state_d = ST_DIV;
      ST_DIV:  if (div_cnt_q == '0) state_d = ST_FIN;
      ST_FIN:  state_d = img_ok ? ST_ADR : ST_IDLE;
      ST_ADR:  state_d = ST_RD;
      ST_RD:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_q      <= '0;
      mrow_q     <= '0;
      mcol_q     <= '0;
      pstep_q    <= 1'b0;
      div_cnt_q  <= '0;
      done_q     <= 1'b0;
      dist_min_q <= 32'hFFFF_FFFF;
      dist_max_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == ST_CHK) && !depth_ok)
              || ((state_q == ST_FIN) && !img_ok) || in_rd;
      if (clearing) clr_q <= clr_q + AW'(1);
      if (accept) begin
        mrow_q <= '0;
        mcol_q <= '0;
      end else if (state_q == ST_MAC) begin
        if (mcol_q == 2'd2) begin
          mcol_q <= '0;
          mrow_q <= mrow_q + 2'd1;
        end else begin
          mcol_q <= mcol_q + 2'd1;
        end
      end
      if (state_q == ST_CHK) pstep_q <= 1'b0;
      else if (state_q == ST_PMUL) pstep_q <= 1'b1;
      if (state_q == ST_PMUL) div_cnt_q <= 7'(psdb_pkg::DVD_W - 1);
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q - 7'd1;
      if (in_rd) begin
        dist_min_q <= min_new;
        dist_max_q <= max_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dx_q     <= dx_in;
        dy_q     <= dy_in;
        dz_q     <= dz_in;
        sample_q <= point_i.sample_value;
        x_q      <= '0;
        y_q      <= '0;
        z_q      <= '0;
        sq_q     <= '0;
        ovf_q    <= 1'b0;
      end
      ST_MAC: begin
        case (mrow_q)
          2'd0:    x_q <= x_q + term_x;
          2'd1:    y_q <= y_q + term_x;
          default: z_q <= z_q + term_x;
        endcase
        if (mrow_q == 2'd0) begin
          sq_q <= sq_sum[63:0];
          // the first square never flags, it has nothing to add to
          if (mcol_q != 2'd0) ovf_q <= ovf_q | sq_sum[64];
        end
      end
      ST_CHK: begin
        mag_x_q <= abs_x[psdb_pkg::MAG_W-1:0];
        mag_y_q <= abs_y[psdb_pkg::MAG_W-1:0];
        neg_x_q <= x_q[psdb_pkg::ACC_W-1];
        neg_y_q <= y_q[psdb_pkg::ACC_W-1];
        dvs_q   <= {z_q[psdb_pkg::DVS_W-5:0], 4'd0};
      end
      ST_PMUL: begin
        if (!pstep_q) begin
          plo_x_q <= pm_x;
          plo_y_q <= pm_y;
        end else begin
          dvd_x_q <= psdb_pkg::DVD_W'(plo_x_q) + {pm_x, 25'd0};
          dvd_y_q <= psdb_pkg::DVD_W'(plo_y_q) + {pm_y, 25'd0};
          rem_x_q <= '0;
          rem_y_q <= '0;
          q_x_q   <= '0;
          q_y_q   <= '0;
          sn_q    <= sq_q;
          sres_q  <= '0;
          sbit_q  <= 64'd1 << 62;
        end
      end
      ST_DIV: begin
        dvd_x_q <= dvd_x_q << 1;
        dvd_y_q <= dvd_y_q << 1;
        rem_x_q <= rem_x_d;
        rem_y_q <= rem_y_d;
        q_x_q   <= q_x_d;
        q_y_q   <= q_y_d;
        if (sbit_q != '0) begin
          if (s_take) begin
            sn_q   <= sn_q - s_trial[63:0];
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_FIN: begin
        col_q     <= c16[4 +: CW];
        row_q     <= r16[4 +: RW];
        pix_col_q <= c16[12:4];
        pix_row_q <= r16[12:4];
        sub_col_q <= c16[3:0];
        sub_row_q <= r16[3:0];
      end
      default: ;
    endcase

    // result register
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while still working");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item did not start");

  a_nearer_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.nearer) |-> result_o.visible) else $error("nearer but not visible");

  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.visible) |->
      (result_o.nearest_seen <= result_o.distance)
      && (result_o.farthest_seen >= result_o.distance))
    else $error("distance outside running extremes");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.visible) |-> (result_o.distance == '0) && !result_o.nearer)
    else $error("dropped item carries data");

endmodule

`default_nettype wire
